// ===== design/trsp_pkg.sv =====
// shared types, widths and codes of the trapezoid step rate profile
package trsp_pkg;

  localparam int unsigned MAX_TOP_DEF = 255;

  localparam int TOP_W      = 8;
  localparam int TIME_W     = 32;
  localparam int PHASE_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = TIME_W + TOP_W;
  localparam int DIV_STEPS  = TOP_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  typedef logic [PHASE_W-1:0] phase_t;

  localparam phase_t PH_ACCEL    = 3'd0;
  localparam phase_t PH_CRUISE   = 3'd1;
  localparam phase_t PH_DECEL    = 3'd2;
  localparam phase_t PH_OVERTIME = 3'd3;
  localparam phase_t PH_START    = 3'd4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TOP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TOP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIME  = 2'd3;

  typedef struct packed {
    logic load;
    logic eval;
    logic mul;
    logic div_step;
    logic finish;
  } trsp_cmd_t;

  typedef struct packed {
    logic div_needed;
  } trsp_stat_t;

endpackage

// ===== design/trsp_in_if.sv =====
// request channel into the profile generator
interface trsp_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] now_us;

  modport source (output valid, command, now_us, input ready);
  modport sink (input valid, command, now_us, output ready);
endinterface

// ===== design/trsp_out_if.sv =====
// result channel out of the profile generator
interface trsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] top_value;
  logic       changed;
  logic [2:0] phase;

  modport source (output valid, top_value, changed, phase, input ready);
  modport sink (input valid, top_value, changed, phase, output ready);
endinterface

// ===== design/trsp_ctrl.sv =====
// sequencing state machine of the profile generator
module trsp_ctrl
  import trsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  trsp_stat_t stat,
  output trsp_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = stat.div_needed ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait until the output register is free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/trsp_dp.sv =====
// registers, phase selection, multiplier and shift-subtract divider
module trsp_dp
  import trsp_pkg::*;
#(
  parameter int unsigned MAX_TOP = MAX_TOP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_command,
  input  logic [TIME_W-1:0]     in_now_us,
  input  trsp_cmd_t             cmd,
  output trsp_stat_t            stat,
  output logic [TOP_W-1:0]      out_top_value,
  output logic                  out_changed,
  output phase_t                out_phase
);

  localparam logic [TOP_W-1:0] MAX_TOP_LIM =
    (MAX_TOP > 255) ? 8'hFF : TOP_W'(MAX_TOP);

  logic [TOP_W-1:0]  target_r, start_r;
  logic [TIME_W-1:0] total_r, ramp_r;
  logic [TIME_W-1:0] stamp_r;
  logic [TOP_W-1:0]  cur_r;

  logic              cmd_r;
  logic [TIME_W-1:0] now_r;
  phase_t            phase_r;
  logic [TIME_W-1:0] mult_r;
  logic              div_r;
  logic [TIME_W-1:0] rem_r;
  logic [TOP_W-1:0]  qsh_r;

  logic [TOP_W-1:0]  top_r;
  logic              changed_r;
  phase_t            phase_out_r;

  logic [TOP_W-1:0]  s_lvl, t_lvl, d_lvl;
  logic [TIME_W-1:0] elapsed, cruise_end, win;
  phase_t            phase_nxt;
  logic [TIME_W-1:0] mult_nxt;
  logic              div_nxt;
  logic [PROD_W-1:0] prod;
  logic [TIME_W:0]   rem_sh, rem_diff;
  logic              rem_ge;
  logic [TOP_W:0]    ceil_q;
  logic [TOP_W-1:0]  top_nxt;

  // clamped levels from the registers in force now
  always_comb begin
    s_lvl = (start_r > MAX_TOP_LIM) ? MAX_TOP_LIM : start_r;
    t_lvl = (target_r > s_lvl) ? s_lvl : target_r;
    d_lvl = s_lvl - t_lvl;
  end

  always_comb begin
    elapsed    = now_r - stamp_r;
    cruise_end = total_r - ramp_r;
    win        = total_r - elapsed;
    phase_nxt  = PH_OVERTIME;
    mult_nxt   = '0;
    div_nxt    = 1'b0;
    if (cmd_r == CMD_START) begin
      phase_nxt = PH_START;
    end else if (elapsed < ramp_r) begin
      phase_nxt = PH_ACCEL;
      mult_nxt  = elapsed;
      div_nxt   = 1'b1;
    end else if (elapsed < cruise_end) begin
      phase_nxt = PH_CRUISE;
    end else if (elapsed < total_r) begin
      phase_nxt = PH_DECEL;
      if (ramp_r != '0 && win <= ramp_r) begin
        mult_nxt = ramp_r - win;
        div_nxt  = 1'b1;
      end
    end
  end

  assign prod = PROD_W'(mult_r) * PROD_W'(d_lvl);

  // one quotient bit a step; the partial remainder always stays below the ramp time
  always_comb begin
    rem_sh   = {rem_r, qsh_r[TOP_W-1]};
    rem_ge   = rem_sh >= {1'b0, ramp_r};
    rem_diff = rem_sh - {1'b0, ramp_r};
  end

  always_comb begin
    ceil_q  = {1'b0, qsh_r} + ((rem_r != '0) ? 9'd1 : 9'd0);
    top_nxt = s_lvl;
    case (phase_r)
      PH_ACCEL:    top_nxt = s_lvl - ceil_q[TOP_W-1:0];
      PH_CRUISE:   top_nxt = t_lvl;
      PH_DECEL:    top_nxt = t_lvl + qsh_r;
      PH_OVERTIME: top_nxt = s_lvl;
      PH_START:    top_nxt = s_lvl;
      default:     top_nxt = s_lvl;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      start_r  <= 8'hFF;
      total_r  <= '0;
      ramp_r   <= '0;
      stamp_r  <= '0;
      cur_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TARGET_TOP: target_r <= cfg_data[TOP_W-1:0];
          REG_START_TOP:  start_r  <= cfg_data[TOP_W-1:0];
          REG_TOTAL_TIME: total_r  <= cfg_data[TIME_W-1:0];
          REG_RAMP_TIME:  ramp_r   <= cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      if (cmd.finish) begin
        cur_r <= top_nxt;
        if (phase_r == PH_START) begin
          stamp_r <= now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      now_r <= in_now_us;
    end
    if (cmd.eval) begin
      phase_r <= phase_nxt;
      mult_r  <= mult_nxt;
      div_r   <= div_nxt;
    end
    if (cmd.mul) begin
      rem_r <= prod[PROD_W-1:TOP_W];
      qsh_r <= prod[TOP_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      qsh_r <= {qsh_r[TOP_W-2:0], rem_ge};
    end
    if (cmd.finish) begin
      top_r       <= top_nxt;
      changed_r   <= (top_nxt != cur_r);
      phase_out_r <= phase_r;
    end
  end

  assign stat.div_needed = div_r;
  assign out_top_value   = top_r;
  assign out_changed     = changed_r;
  assign out_phase       = phase_out_r;

endmodule

// ===== design/trapezoid_step_rate_profile.sv =====
// Trapezoidal step rate profile: turns a microsecond timestamp into a stepper timer top
// value. A start request (command 0) stores its timestamp and loads the start top clamped
// to MAX_TOP; a tick request (command 1) measures the time since that start and returns the
// accelerate, cruise, decelerate or overtime top value, with a flag set when it differs from
// the value before. Ramp values come from a 32 x 8 bit multiply followed by an eight step
// shift-subtract divide by the ramp time, one quotient bit per cycle. A tick that falls in a
// ramp passes through accept, evaluate, multiply, 8 divide steps and finish before the next
// request is taken; start requests and ticks in cruise or overtime skip the divide. The finish
// step waits for as long as an earlier result is still held in the output register. One
// request is worked on at a time; a finished result waits in the output register while the
// next request is taken. Configuration must only be written while no request is in flight.
module trapezoid_step_rate_profile
  import trsp_pkg::*;
#(
  parameter int unsigned MAX_TOP = MAX_TOP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  trsp_in_if.sink               in_ch,
  trsp_out_if.source            out_ch
);

  trsp_cmd_t  cmd;
  trsp_stat_t stat;

  trsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  trsp_dp #(
    .MAX_TOP (MAX_TOP)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .in_command    (in_ch.command),
    .in_now_us     (in_ch.now_us),
    .cmd           (cmd),
    .stat          (stat),
    .out_top_value (out_ch.top_value),
    .out_changed   (out_ch.changed),
    .out_phase     (out_ch.phase)
  );

  // the block is not ready in the cycle after it takes a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while the previous one is still being evaluated");

  // a new result only appears at the end of work on a request
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result raised without a request in progress");

endmodule
